FILE: rtl/core/bfab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfab_pkg
// Shared types, register indexes and arithmetic helpers for the bilinear
// filter, modulate and alpha blend pipeline.
// ----------------------------------------------------------------------------
package bfab_pkg;

  localparam int CHAN_W  = 8;
  localparam int PROD_W  = 16;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_MOD_ALPHA = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_RED   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_GREEN = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_BLUE  = 8'd3;

  localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'd255;
  localparam logic [PROD_W-1:0] ROUND_255 = 16'd127;

  typedef enum logic [1:0] {
    MODE_SKIP,
    MODE_COPY,
    MODE_BLEND
  } bfab_mode_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } bfab_adv_t;

  // Exact floor(x / 255) for any x below 256 * 255.
  function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
    logic [31:0] p;
    p = 32'(x) * 32'h0000_8081;
    return p[30:23];
  endfunction

endpackage

FILE: rtl/core/bfab_bilerp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfab_bilerp
// One channel lane of the bilinear filter: x interpolation of the top and
// bottom rows in the first stage, y interpolation in the second.
// ----------------------------------------------------------------------------
module bfab_bilerp #(
  parameter int FRAC_BITS = 8
) (
  input  logic                      clk,
  input  bfab_pkg::bfab_adv_t       adv,
  input  logic [7:0]                top_left,
  input  logic [7:0]                top_right,
  input  logic [7:0]                bottom_left,
  input  logic [7:0]                bottom_right,
  input  logic [FRAC_BITS-1:0]      fx,
  input  logic [FRAC_BITS-1:0]      fy1,
  output logic [7:0]                sample
);
  import bfab_pkg::*;

  localparam int SW = FRAC_BITS + 10;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);

  function automatic logic [7:0] lerp(input logic [7:0] a, input logic [7:0] b,
                                      input logic [FRAC_BITS-1:0] f);
    logic [FRAC_BITS:0] wa;
    logic [SW-1:0]      sum;
    wa  = ONE - (FRAC_BITS+1)'(f);
    sum = SW'(wa) * SW'(a) + SW'(f) * SW'(b) + HALF;
    return sum[FRAC_BITS+7:FRAC_BITS];
  endfunction

  logic [7:0] row_top;
  logic [7:0] row_bottom;

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      row_top    <= lerp(top_left, top_right, fx);
      row_bottom <= lerp(bottom_left, bottom_right, fx);
    end
    if (adv.s2) begin
      sample <= lerp(row_top, row_bottom, fy1);
    end
  end

endmodule

FILE: rtl/core/bfab_modblend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfab_modblend
// One color lane: tint modulate, divide by 255, blend over the destination
// and select the final channel value by the alpha mode.
// ----------------------------------------------------------------------------
module bfab_modblend (
  input  logic                 clk,
  input  bfab_pkg::bfab_adv_t  adv,
  input  logic [7:0]           sample,
  input  logic [7:0]           tint,
  input  logic [7:0]           dest,
  input  logic [7:0]           alpha,
  input  bfab_pkg::bfab_mode_t mode,
  output logic [7:0]           result
);
  import bfab_pkg::*;

  logic [PROD_W-1:0] prod3;
  logic [7:0]        dest3;
  logic [7:0]        mod4;
  logic [7:0]        dest4;
  logic [PROD_W-1:0] bprod5;
  logic [7:0]        mod5;
  logic [7:0]        dest5;
  logic [7:0]        result_next;

  always_comb begin
    case (mode)
      MODE_SKIP:  result_next = dest5;
      MODE_COPY:  result_next = mod5;
      MODE_BLEND: result_next = div255(bprod5);
      default:    result_next = div255(bprod5);
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      prod3 <= PROD_W'(sample) * PROD_W'(tint) + ROUND_255;
      dest3 <= dest;
    end
    if (adv.s4) begin
      mod4  <= div255(prod3);
      dest4 <= dest3;
    end
    if (adv.s5) begin
      bprod5 <= PROD_W'(mod4) * PROD_W'(alpha)
              + PROD_W'(dest4) * PROD_W'(CHAN_MAX - alpha) + ROUND_255;
      mod5   <= mod4;
      dest5  <= dest4;
    end
    if (adv.s6) begin
      result <= result_next;
    end
  end

endmodule

FILE: rtl/core/bilinear_modulate_alpha_blend_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_modulate_alpha_blend_top
// Bilinear texel filter with modulate and alpha blend, one pixel per item.
// ----------------------------------------------------------------------------
// Six-stage pipeline taking one item per clock unless out_stall backs up into
// the first stage. Stages: x lerp, y lerp, modulate product, divide by 255,
// blend product, divide and select into the output register. Four lanes
// filter R, G, B and A side by side; the alpha path picks skip, copy or blend
// for the three color lanes. A stage holds only when the stage after it is full
// and holding, so bubbles collapse and an item enters while a result waits at
// the output. The user must write registers through the cfg port only while
// the block is idle (not enforced by the block); indexes above 3 are ignored.
// ----------------------------------------------------------------------------
module bilinear_modulate_alpha_blend_top #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] texel_top_left,
  input  logic [31:0] texel_top_right,
  input  logic [31:0] texel_bottom_left,
  input  logic [31:0] texel_bottom_right,
  input  logic [7:0]  frac_x,
  input  logic [7:0]  frac_y,
  input  logic [7:0]  dest_red,
  input  logic [7:0]  dest_green,
  input  logic [7:0]  dest_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        write_pixel,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [bfab_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]  cfg_data
);
  import bfab_pkg::*;

  localparam int NSTG = 6;

  logic [7:0] mod_alpha;
  logic [7:0] mod_red;
  logic [7:0] mod_green;
  logic [7:0] mod_blue;

  logic [NSTG:1]   vld;
  logic [NSTG:1]   vld_next;
  logic [NSTG+1:1] rdy;
  logic [NSTG:1]   adv_vec;
  bfab_adv_t       adv;

  logic [FRAC_BITS-1:0] fx;
  logic [FRAC_BITS-1:0] fy;
  logic [FRAC_BITS-1:0] fy1;
  logic [23:0]          dest1;
  logic [23:0]          dest2;

  logic [7:0] sample [4];
  logic [7:0] tint [3];
  logic [7:0] result [3];

  logic [PROD_W-1:0] aprod3;
  logic [7:0]        alpha4;
  bfab_mode_t        mode5;
  bfab_mode_t        mode5_next;
  logic              write6;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_alpha <= CHAN_MAX;
      mod_red   <= CHAN_MAX;
      mod_green <= CHAN_MAX;
      mod_blue  <= CHAN_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MOD_ALPHA: mod_alpha <= cfg_data;
        REG_MOD_RED:   mod_red   <= cfg_data;
        REG_MOD_GREEN: mod_green <= cfg_data;
        REG_MOD_BLUE:  mod_blue  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance a stage when its successor is empty or advancing.
  always_comb begin
    rdy[NSTG+1] = !out_stall;
    for (int i = NSTG; i >= 1; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
    adv_vec[1] = in_valid && rdy[1];
    for (int i = 2; i <= NSTG; i++) begin
      adv_vec[i] = vld[i-1] && rdy[i];
    end
    for (int i = 1; i <= NSTG; i++) begin
      vld_next[i] = adv_vec[i] || (vld[i] && !rdy[i+1]);
    end
  end

  assign adv.s1 = adv_vec[1];
  assign adv.s2 = adv_vec[2];
  assign adv.s3 = adv_vec[3];
  assign adv.s4 = adv_vec[4];
  assign adv.s5 = adv_vec[5];
  assign adv.s6 = adv_vec[6];

  assign in_stall  = !rdy[1];
  assign out_valid = vld[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign fx = FRAC_BITS'(frac_x);
  assign fy = FRAC_BITS'(frac_y);

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      fy1   <= fy;
      dest1 <= {dest_blue, dest_green, dest_red};
    end
    if (adv.s2) begin
      dest2 <= dest1;
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_filter
    bfab_bilerp #(
      .FRAC_BITS(FRAC_BITS)
    ) u_bilerp (
      .clk          (clk),
      .adv          (adv),
      .top_left     (texel_top_left[8*c +: 8]),
      .top_right    (texel_top_right[8*c +: 8]),
      .bottom_left  (texel_bottom_left[8*c +: 8]),
      .bottom_right (texel_bottom_right[8*c +: 8]),
      .fx           (fx),
      .fy1          (fy1),
      .sample       (sample[c])
    );
  end

  assign tint[0] = mod_red;
  assign tint[1] = mod_green;
  assign tint[2] = mod_blue;

  always_comb begin
    if (alpha4 == '0) begin
      mode5_next = MODE_SKIP;
    end else if (alpha4 == CHAN_MAX) begin
      mode5_next = MODE_COPY;
    end else begin
      mode5_next = MODE_BLEND;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      aprod3 <= PROD_W'(sample[3]) * PROD_W'(mod_alpha) + ROUND_255;
    end
    if (adv.s4) begin
      alpha4 <= div255(aprod3);
    end
    if (adv.s5) begin
      mode5 <= mode5_next;
    end
    if (adv.s6) begin
      write6 <= (mode5 != MODE_SKIP);
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_color
    bfab_modblend u_modblend (
      .clk    (clk),
      .adv    (adv),
      .sample (sample[c]),
      .tint   (tint[c]),
      .dest   (dest2[8*c +: 8]),
      .alpha  (alpha4),
      .mode   (mode5),
      .result (result[c])
    );
  end

  assign out_red     = result[0];
  assign out_green   = result[1];
  assign out_blue    = result[2];
  assign write_pixel = write6;

endmodule
